/* hw/rtl/nlff_pkg.sv */
// Shared types and constants of the neighbor label frequency filter.
`timescale 1ns / 1ps
`default_nettype none
package nlff_pkg;

  localparam int CMD_BITS    = 2;
  localparam int THR_BITS    = 16;
  localparam int DEF_BITS    = THR_BITS + 1;
  localparam int REASON_BITS = 3;

  localparam logic [CMD_BITS-1:0] CMD_START_QUERY = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD_REQ     = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_START_DATA  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_DATA_FREQ   = 2'd3;

  localparam logic [REASON_BITS-1:0] REJ_NONE       = 3'd0;
  localparam logic [REASON_BITS-1:0] REJ_LABEL      = 3'd1;
  localparam logic [REASON_BITS-1:0] REJ_BRIDGE_DEG = 3'd2;
  localparam logic [REASON_BITS-1:0] REJ_DEGREE     = 3'd3;
  localparam logic [REASON_BITS-1:0] REJ_BRIDGE     = 3'd4;
  localparam logic [REASON_BITS-1:0] REJ_DEFICIT    = 3'd5;

  typedef struct packed {
    logic load_query;
    logic add_req;
    logic start_data;
    logic latch_item;
    logic rd_en;
    logic settle;
    logic use_count;
    logic emit;
  } nlff_cmd_t;

  typedef struct packed {
    logic rej_clear;
    logic more_reqs;
    logic lbl_lt;
    logic lbl_eq;
    logic out_busy;
  } nlff_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/nlff_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nlff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/nlff_ctrl.sv */
// Controller state machine that sequences the requirement merge.
`timescale 1ns / 1ps
`default_nettype none
module nlff_ctrl
  import nlff_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [CMD_BITS-1:0] command_i,
  input  wire logic                is_last_i,
  input  wire nlff_sts_t           sts_i,
  output logic                     in_stall_o,
  output nlff_cmd_t                cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       last_q, last_d;
  logic       tail_q, tail_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    tail_d  = tail_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_START_QUERY: cmd_o.load_query = 1'b1;
            CMD_ADD_REQ:     cmd_o.add_req = 1'b1;
            CMD_START_DATA: begin
              cmd_o.start_data = 1'b1;
              last_d = is_last_i;
              tail_d = 1'b1;
              if (is_last_i) begin
                state_d = ST_FETCH;
              end
            end
            default: begin
              cmd_o.latch_item = 1'b1;
              last_d  = is_last_i;
              tail_d  = 1'b0;
              state_d = ST_FETCH;
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (sts_i.rej_clear && sts_i.more_reqs) begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_EVAL;
        end else if (last_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EVAL: begin
        cmd_o.settle = tail_q | sts_i.lbl_lt | sts_i.lbl_eq | last_q;
        cmd_o.use_count = !tail_q && sts_i.lbl_eq;
        if (!tail_q && !sts_i.lbl_lt && !last_q) begin
          state_d = ST_IDLE;
        end else begin
          tail_d  = tail_q | !sts_i.lbl_lt;
          state_d = ST_FETCH;
        end
      end
      default: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
      tail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      tail_q  <= tail_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/nlff_dp.sv */
// Datapath: query registers, requirement memory, settle arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module nlff_dp
  import nlff_pkg::*;
#(
  parameter int MAX_REQS   = 32,
  parameter int LABEL_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire nlff_cmd_t              cmd_i,
  output nlff_sts_t                   sts_o,
  input  wire logic [LABEL_BITS-1:0]  label_i,
  input  wire logic [COUNT_BITS-1:0]  first_count_i,
  input  wire logic [COUNT_BITS-1:0]  second_count_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [THR_BITS-1:0]    cfg_wdata_i,
  input  wire logic                   out_stall_i,
  output logic                        out_valid_o,
  output logic                        accept_o,
  output logic [DEF_BITS-1:0]         deficit_o,
  output logic [REASON_BITS-1:0]      reject_reason_o
);

  localparam int AW    = (MAX_REQS > 1) ? $clog2(MAX_REQS) : 1;
  localparam int CW    = $clog2(MAX_REQS + 1);
  localparam int WW    = LABEL_BITS + 2 * COUNT_BITS;
  localparam int SUM_W = ((COUNT_BITS > DEF_BITS) ? COUNT_BITS : DEF_BITS) + 1;
  localparam int DEG_W = ((COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS) + 1;

  logic [THR_BITS-1:0]    thr_q;
  logic [LABEL_BITS-1:0]  qlabel_q;
  logic [COUNT_BITS-1:0]  qdeg_q;
  logic [COUNT_BITS-1:0]  qbridge_q;
  logic [CW-1:0]          cnt_q;
  logic [CW-1:0]          ptr_q;
  logic [DEF_BITS-1:0]    def_q;
  logic [REASON_BITS-1:0] rej_q;
  logic [LABEL_BITS-1:0]  item_label_q;
  logic [COUNT_BITS-1:0]  item_count_q;
  logic                   out_valid_q;

  logic                   wr_en;
  logic [WW-1:0]          rdata;
  logic [LABEL_BITS-1:0]  ent_label;
  logic [COUNT_BITS-1:0]  ent_bridge;
  logic [COUNT_BITS-1:0]  ent_normal;
  logic [COUNT_BITS-1:0]  eff_c;
  logic [COUNT_BITS-1:0]  avail;
  logic [COUNT_BITS-1:0]  diff;
  logic [SUM_W-1:0]       sum;
  logic                   short;
  logic                   over;
  logic [DEF_BITS-1:0]    sat;
  logic [DEG_W-1:0]       deg_lim;
  logic [REASON_BITS-1:0] start_rej;

  assign wr_en = cmd_i.add_req && (cnt_q < CW'(MAX_REQS));

  nlff_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_REQS)
  ) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({label_i, first_count_i, second_count_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign ent_label  = rdata[WW-1 -: LABEL_BITS];
  assign ent_bridge = rdata[2*COUNT_BITS-1 -: COUNT_BITS];
  assign ent_normal = rdata[COUNT_BITS-1:0];

  assign eff_c = cmd_i.use_count ? item_count_q : '0;
  assign short = ent_bridge > eff_c;
  assign avail = eff_c - ent_bridge;
  assign diff  = (ent_normal > avail) ? (ent_normal - avail) : '0;
  assign sum   = SUM_W'(def_q) + SUM_W'(diff);
  assign over  = sum > SUM_W'(thr_q);
  assign sat   = DEF_BITS'(thr_q) + DEF_BITS'(1);

  assign deg_lim = DEG_W'(first_count_i) + DEG_W'(thr_q);

  always_comb begin
    if (label_i != qlabel_q) begin
      start_rej = REJ_LABEL;
    end else if (qbridge_q > first_count_i) begin
      start_rej = REJ_BRIDGE_DEG;
    end else if (DEG_W'(qdeg_q) > deg_lim) begin
      start_rej = REJ_DEGREE;
    end else begin
      start_rej = REJ_NONE;
    end
  end

  assign sts_o.rej_clear = (rej_q == REJ_NONE);
  assign sts_o.more_reqs = (ptr_q < cnt_q);
  assign sts_o.lbl_lt    = (ent_label < item_label_q);
  assign sts_o.lbl_eq    = (ent_label == item_label_q);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      qlabel_q    <= '0;
      qdeg_q      <= '0;
      qbridge_q   <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      def_q       <= '0;
      rej_q       <= REJ_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.load_query) begin
        qlabel_q  <= label_i;
        qdeg_q    <= first_count_i;
        qbridge_q <= second_count_i;
        cnt_q     <= '0;
      end else if (wr_en) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.start_data) begin
        ptr_q <= '0;
        def_q <= '0;
        rej_q <= start_rej;
      end else if (cmd_i.settle) begin
        ptr_q <= ptr_q + CW'(1);
        if (short) begin
          def_q <= sat;
          rej_q <= REJ_BRIDGE;
        end else if (over) begin
          def_q <= sat;
          rej_q <= REJ_DEFICIT;
        end else begin
          def_q <= DEF_BITS'(sum);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_label_q <= label_i;
      item_count_q <= first_count_i;
    end
    if (cmd_i.emit) begin
      accept_o        <= (rej_q == REJ_NONE);
      deficit_o       <= def_q;
      reject_reason_o <= rej_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* hw/rtl/neighbor_label_frequency_filter.sv */
// Top level of the neighbor label frequency filter.
`timescale 1ns / 1ps
`default_nettype none
// Commands that load the query vertex or append a requirement are accepted without stalling
// the input, as is a data vertex start without its last flag. A frequency beat, or a start
// beat with the last flag, stalls the input while the merge runs: each pointer check and each
// requirement read is a controller state of its own, because the requirement memory has a
// registered read and the merge walks it one entry at a time; a beat that ends a data
// vertex then loads the result register, which waits while a previous result
// is stalled. The requirement memory needs no clearing after reset.
module neighbor_label_frequency_filter
  import nlff_pkg::*;
#(
  parameter int MAX_REQS   = 32,
  parameter int LABEL_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CMD_BITS-1:0]    command_i,
  input  wire logic [LABEL_BITS-1:0]  label_i,
  input  wire logic [COUNT_BITS-1:0]  first_count_i,
  input  wire logic [COUNT_BITS-1:0]  second_count_i,
  input  wire logic                   is_last_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [THR_BITS-1:0]    cfg_wdata_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        accept_o,
  output logic [DEF_BITS-1:0]         deficit_o,
  output logic [REASON_BITS-1:0]      reject_reason_o
);

  nlff_cmd_t cmd;
  nlff_sts_t sts;

  nlff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .is_last_i  (is_last_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  nlff_dp #(
    .MAX_REQS   (MAX_REQS),
    .LABEL_BITS (LABEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .label_i         (label_i),
    .first_count_i   (first_count_i),
    .second_count_i  (second_count_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .accept_o        (accept_o),
    .deficit_o       (deficit_o),
    .reject_reason_o (reject_reason_o)
  );

  // Early rejects never run the merge, so they report no deficit.
  a_early_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reject_reason_o == REJ_LABEL || reject_reason_o == REJ_BRIDGE_DEG ||
                    reject_reason_o == REJ_DEGREE) |-> deficit_o == '0)
    else $error("early reject reported a nonzero deficit");

  a_freq_starts_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i == CMD_DATA_FREQ |=> in_stall_o)
    else $error("frequency beat did not start the merge");

  a_query_beats_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (command_i == CMD_START_QUERY || command_i == CMD_ADD_REQ) |=> !in_stall_o)
    else $error("query load beat stalled the input");

endmodule
`default_nettype wire

/* tb/nlff_checker.sv */
// Checker that predicts and compares the verdicts of the neighbor label frequency filter.
`timescale 1ns / 1ps
module nlff_checker
  import nlff_pkg::*;
#(
  parameter int MAX_REQS   = 32,
  parameter int LABEL_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [CMD_BITS-1:0]    command_i,
  input  logic [LABEL_BITS-1:0]  label_i,
  input  logic [COUNT_BITS-1:0]  first_count_i,
  input  logic [COUNT_BITS-1:0]  second_count_i,
  input  logic                   is_last_i,
  input  logic                   cfg_we_i,
  input  logic [THR_BITS-1:0]    cfg_wdata_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic                   accept_i,
  input  logic [DEF_BITS-1:0]    deficit_i,
  input  logic [REASON_BITS-1:0] reject_reason_i,
  output int                     mismatches_o,
  output int                     verdicts_o,
  output int                     pending_o
);

  typedef struct packed {
    logic                   accept;
    logic [DEF_BITS-1:0]    deficit;
    logic [REASON_BITS-1:0] reason;
  } filter_verdict_t;

  filter_verdict_t pending_verdicts[$];
  filter_verdict_t head;

  logic [THR_BITS-1:0]    thr_m;
  logic [LABEL_BITS-1:0]  req_lbl [MAX_REQS];
  logic [COUNT_BITS-1:0]  req_brg [MAX_REQS];
  logic [COUNT_BITS-1:0]  req_nrm [MAX_REQS];
  int                     req_total;
  int                     walk_ptr;
  logic [LABEL_BITS-1:0]  qry_label;
  logic [COUNT_BITS-1:0]  qry_degree;
  logic [COUNT_BITS-1:0]  qry_bridge;
  logic [DEF_BITS-1:0]    deficit_m;
  logic [REASON_BITS-1:0] reason_m;

  int mismatches = 0;
  int verdicts_seen = 0;

  assign mismatches_o = mismatches;
  assign verdicts_o   = verdicts_seen;

  task automatic report(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 30) begin
      $display("mismatch at %0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Settles the requirement under the merge pointer against a data count.
  task automatic settle_req(input logic [COUNT_BITS-1:0] cnt);
    int                    idx;
    logic [COUNT_BITS-1:0] avail;
    logic [DEF_BITS:0]     acc;
    if (walk_ptr >= req_total) return;
    idx = walk_ptr;
    walk_ptr++;
    if (req_brg[idx] > cnt) begin
      reason_m  = REJ_BRIDGE;
      deficit_m = DEF_BITS'(thr_m) + DEF_BITS'(1);
    end else begin
      avail = cnt - req_brg[idx];
      acc   = {1'b0, deficit_m};
      if (req_nrm[idx] > avail) acc = acc + (DEF_BITS+1)'(req_nrm[idx] - avail);
      if (acc > (DEF_BITS+1)'(thr_m)) begin
        deficit_m = DEF_BITS'(thr_m) + DEF_BITS'(1);
        reason_m  = REJ_DEFICIT;
      end else begin
        deficit_m = acc[DEF_BITS-1:0];
      end
    end
  endtask

  task automatic apply_filter_beat(input logic [CMD_BITS-1:0] cmd,
                                   input logic [LABEL_BITS-1:0] lbl,
                                   input logic [COUNT_BITS-1:0] c1,
                                   input logic [COUNT_BITS-1:0] c2,
                                   input logic last);
    logic [COUNT_BITS:0] room;
    filter_verdict_t     v;
    case (cmd)
      CMD_START_QUERY: begin
        qry_label  = lbl;
        qry_degree = c1;
        qry_bridge = c2;
        req_total  = 0;
      end
      CMD_ADD_REQ: begin
        if (req_total < MAX_REQS) begin
          req_lbl[req_total] = lbl;
          req_brg[req_total] = c1;
          req_nrm[req_total] = c2;
          req_total++;
        end
      end
      CMD_START_DATA: begin
        walk_ptr  = 0;
        deficit_m = '0;
        room      = (COUNT_BITS+1)'(c1) + (COUNT_BITS+1)'(thr_m);
        if (lbl != qry_label) reason_m = REJ_LABEL;
        else if (qry_bridge > c1) reason_m = REJ_BRIDGE_DEG;
        else if ({1'b0, qry_degree} > room) reason_m = REJ_DEGREE;
        else reason_m = REJ_NONE;
      end
      default: begin
        while (reason_m == REJ_NONE && walk_ptr < req_total && req_lbl[walk_ptr] < lbl) begin
          settle_req('0);
        end
        if (reason_m == REJ_NONE && walk_ptr < req_total && req_lbl[walk_ptr] == lbl) begin
          settle_req(c1);
        end
      end
    endcase
    if (last && (cmd == CMD_START_DATA || cmd == CMD_DATA_FREQ)) begin
      while (reason_m == REJ_NONE && walk_ptr < req_total) settle_req('0);
      v.accept  = (reason_m == REJ_NONE);
      v.deficit = deficit_m;
      v.reason  = reason_m;
      pending_verdicts.insert(pending_verdicts.size(), v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_m      = '0;
      req_total  = 0;
      walk_ptr   = 0;
      qry_label  = '0;
      qry_degree = '0;
      qry_bridge = '0;
      deficit_m  = '0;
      reason_m   = REJ_NONE;
      foreach (req_lbl[k]) begin
        req_lbl[k] = '0;
        req_brg[k] = '0;
        req_nrm[k] = '0;
      end
      pending_verdicts.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) thr_m = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          report("verdict beat with none pending, deficit", 0, int'(deficit_i));
        end else begin
          head = pending_verdicts.pop_front();
          verdicts_seen++;
          if (accept_i !== head.accept) begin
            report("accept", int'(head.accept), int'(accept_i));
          end
          if (deficit_i !== head.deficit) begin
            report("deficit", int'(head.deficit), int'(deficit_i));
          end
          if (reject_reason_i !== head.reason) begin
            report("reject_reason", int'(head.reason), int'(reject_reason_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_filter_beat(command_i, label_i, first_count_i, second_count_i, is_last_i);
      end
      pending_o <= pending_verdicts.size();
    end
  end

endmodule

/* tb/neighbor_label_frequency_filter_tb.sv */
// Testbench top that drives query and data vertex beats into the filter and gives the verdict.
`timescale 1ns / 1ps
module neighbor_label_frequency_filter_tb;
  import nlff_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int QUIET_CYCLES = 150;
  localparam int PHASE_BEATS  = 120;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic [CMD_BITS-1:0]    command_i = '0;
  logic [15:0]            label_i = '0;
  logic [15:0]            first_count_i = '0;
  logic [15:0]            second_count_i = '0;
  logic                   is_last_i = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [THR_BITS-1:0]    cfg_wdata_i = '0;
  logic                   out_stall_i = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic                   accept_o;
  logic [DEF_BITS-1:0]    deficit_o;
  logic [REASON_BITS-1:0] reject_reason_o;

  int mismatches;
  int verdicts;
  int pending;

  logic calm = 1'b0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   beats_sent = 0;
  int   ignored_beats = 0;

  logic [15:0] trk_lbl [32];
  logic [15:0] trk_brg [32];
  logic [15:0] trk_nrm [32];
  int          trk_n = 0;
  logic [15:0] ent_lbl [128];
  logic [15:0] ent_cnt [128];
  int          ent_n = 0;

  neighbor_label_frequency_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .label_i         (label_i),
    .first_count_i   (first_count_i),
    .second_count_i  (second_count_i),
    .is_last_i       (is_last_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accept_o        (accept_o),
    .deficit_o       (deficit_o),
    .reject_reason_o (reject_reason_o)
  );

  nlff_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .command_i       (command_i),
    .label_i         (label_i),
    .first_count_i   (first_count_i),
    .second_count_i  (second_count_i),
    .is_last_i       (is_last_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accept_i        (accept_o),
    .deficit_i       (deficit_o),
    .reject_reason_i (reject_reason_o),
    .mismatches_o    (mismatches),
    .verdicts_o      (verdicts),
    .pending_o       (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[neighbor_label_frequency_filter] ERROR");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left = idle_len();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // Valid stays high from one beat to the next unless a gap is inserted.
  task automatic send_beat(input logic [CMD_BITS-1:0] cmd, input logic [15:0] lbl,
                           input logic [15:0] c1, input logic [15:0] c2, input logic last);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    label_i        <= lbl;
    first_count_i  <= c1;
    second_count_i <= c2;
    is_last_i      <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic add_requirement(input logic [15:0] lbl, input logic [15:0] brg,
                                 input logic [15:0] nrm);
    send_beat(CMD_ADD_REQ, lbl, brg, nrm, 1'($urandom_range(0, 1)));
    if (trk_n < 32) begin
      trk_lbl[trk_n] = lbl;
      trk_brg[trk_n] = brg;
      trk_nrm[trk_n] = nrm;
      trk_n++;
    end else begin
      ignored_beats++;
    end
  endtask

  task automatic add_entry(input logic [15:0] lbl, input logic [15:0] cnt);
    if (ent_n < 128) begin
      ent_lbl[ent_n] = lbl;
      ent_cnt[ent_n] = cnt;
      ent_n++;
    end
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_BITS-1:0] value);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int          r;
    int          n;
    int          d;
    int          idx;
    int          phase;
    int          goal;
    int          lbl_next;
    logic [15:0] q_lab;
    logic [15:0] q_deg;
    logic [15:0] q_brg;
    logic [15:0] lab;
    logic [15:0] v1;
    logic [15:0] v2;
    logic [15:0] v3;

    q_lab = '0;
    q_deg = '0;
    q_brg = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_threshold(16'd3);
    send_beat(CMD_START_QUERY, 16'hFFFF, 16'd5, 16'd1, 1'b0);
    add_requirement(16'h0000, 16'd0, 16'd2);
    add_requirement(16'h0010, 16'd1, 16'd1);
    add_requirement(16'hFFFF, 16'd0, 16'd1);
    send_beat(CMD_START_DATA, 16'hFFFF, 16'd5, 16'hFFFF, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0000, 16'd2, 16'hFFFF, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0010, 16'd2, 16'h0000, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'hFFFF, 16'd1, 16'hFFFF, 1'b1);
    send_beat(CMD_START_DATA, 16'h1234, 16'd5, 16'd0, 1'b1);
    send_beat(CMD_START_DATA, 16'hFFFF, 16'd0, 16'd0, 1'b1);
    send_beat(CMD_START_DATA, 16'hFFFF, 16'd1, 16'd0, 1'b1);
    send_beat(CMD_START_DATA, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0010, 16'd0, 16'd0, 1'b1);
    // Out-of-order and repeated labels match nothing and end in a deficit reject.
    send_beat(CMD_START_DATA, 16'hFFFF, 16'd5, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0000, 16'd0, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0010, 16'd1, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0005, 16'hFFFF, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0010, 16'd5, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'hFFFF, 16'd0, 16'd0, 1'b1);
    send_beat(CMD_DATA_FREQ, 16'h0000, 16'd0, 16'd0, 1'b1);
    send_beat(CMD_START_DATA, 16'hFFFF, 16'd5, 16'd0, 1'b1);
    // A requirement appended while a data vertex is being merged.
    send_beat(CMD_START_DATA, 16'hFFFF, 16'd5, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0000, 16'd2, 16'd0, 1'b0);
    send_beat(CMD_DATA_FREQ, 16'h0010, 16'd2, 16'd0, 1'b0);
    add_requirement(16'hFFFF, 16'd0, 16'd2);
    send_beat(CMD_DATA_FREQ, 16'hFFFF, 16'd1, 16'd0, 1'b1);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_threshold(16'd0);
        1: write_threshold(16'hFFFF);
        2: write_threshold(THR_BITS'($urandom_range(1, 20)));
        3: write_threshold(THR_BITS'($urandom_range(0, 65535)));
        default: write_threshold(16'd1);
      endcase
      goal = beats_sent - ignored_beats + PHASE_BEATS;
      while (beats_sent - ignored_beats < goal) begin
        calm <= ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 99) < 85) begin
          if (trk_n == 0 || $urandom_range(0, 2) == 0) begin
            q_lab = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 7));
            q_deg = 16'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 12));
            q_brg = 16'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 3));
            send_beat(CMD_START_QUERY, q_lab, q_deg, q_brg, 1'($urandom_range(0, 1)));
            trk_n = 0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 34) : $urandom_range(0, 6);
            lbl_next = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
            repeat (n) begin
              v1 = 16'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 3));
              v2 = 16'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 4));
              add_requirement(16'(lbl_next), v1, v2);
              lbl_next = lbl_next + (($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 50));
              if (lbl_next > 65535) lbl_next = 65535;
            end
          end
          repeat ($urandom_range(1, 3)) begin
            lab = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) : q_lab;
            d = int'(q_deg) + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 19) == 0) d = $urandom_range(0, 65535);
            if (d < 0) d = 0;
            if (d > 65535) d = 65535;
            ent_n = 0;
            for (idx = 0; idx < trk_n; idx++) begin
              r = $urandom_range(0, 99);
              if (r >= 10) begin
                if (r < 20 && trk_lbl[idx] != 16'd0) begin
                  add_entry(trk_lbl[idx] - 16'd1, 16'($urandom_range(0, 9)));
                end
                n = int'(trk_brg[idx]) + int'(trk_nrm[idx]) + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 19) == 0) n = $urandom_range(0, 65535);
                if (n < 0) n = 0;
                if (n > 65535) n = 65535;
                add_entry(trk_lbl[idx], 16'(n));
                if (r >= 94) begin
                  add_entry(r[0] ? trk_lbl[idx] : (trk_lbl[idx] >> 1),
                            16'($urandom_range(0, 65535)));
                end
              end
            end
            if ($urandom_range(0, 9) == 0) begin
              add_entry(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 9)));
            end
            send_beat(CMD_START_DATA, lab, 16'(d), 16'($urandom_range(0, 65535)), ent_n == 0);
            for (idx = 0; idx < ent_n; idx++) begin
              if ($urandom_range(0, 29) == 0) begin
                add_requirement(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3)),
                                16'($urandom_range(0, 4)));
              end
              send_beat(CMD_DATA_FREQ, ent_lbl[idx], ent_cnt[idx],
                        16'($urandom_range(0, 65535)), idx == ent_n - 1);
            end
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            r  = $urandom_range(0, 3);
            v1 = 16'($urandom_range(0, 65535));
            v2 = 16'($urandom_range(0, 65535));
            v3 = 16'($urandom_range(0, 65535));
            if (r == CMD_ADD_REQ) begin
              add_requirement(v1, v2, v3);
            end else begin
              send_beat(CMD_BITS'(r), v1, v2, v3, 1'($urandom_range(0, 1)));
              if (r == CMD_START_QUERY) begin
                q_lab = v1;
                q_deg = v2;
                q_brg = v3;
                trk_n = 0;
              end
            end
          end
        end
      end
    end

    calm <= 1'b0;
    settle_idle();
    $display("Checked %0d verdicts from %0d input beats, %0d of them dropped on a full list.",
             verdicts, beats_sent, ignored_beats);
    $display("Threshold settings run: 3, 0, 65535, a small and a wide random value, and 1.");
    if (mismatches == 0 && pending == 0) begin
      $display("[neighbor_label_frequency_filter] OK");
    end else begin
      $display("[neighbor_label_frequency_filter] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/nlff_pkg.sv
hw/rtl/nlff_ram.sv
hw/rtl/nlff_ctrl.sv
hw/rtl/nlff_dp.sv
hw/rtl/neighbor_label_frequency_filter.sv
tb/nlff_checker.sv
tb/neighbor_label_frequency_filter_tb.sv
